// File: design/scic_pkg.sv
// Shared types and codes for the switch control interlock.
package scic_pkg;

  // Request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_POS      = 3'd0,
    REQ_OPEN_EN  = 3'd1,
    REQ_CLOSE_EN = 3'd2,
    REQ_LOCAL    = 3'd3,
    REQ_CHECK    = 3'd4,
    REQ_POLL     = 3'd5
  } req_e;

  // Double-point breaker position
  typedef enum logic [1:0] {
    POS_INTERMEDIATE = 2'd0,
    POS_OFF          = 2'd1,
    POS_ON           = 2'd2,
    POS_BAD          = 2'd3
  } pos_e;

  // Result codes
  typedef enum logic [2:0] {
    RC_NONE     = 3'd0,
    RC_ACCEPTED = 3'd1,
    RC_DENIED   = 3'd2,
    RC_OK       = 3'd3,
    RC_FAILED   = 3'd4,
    RC_WAITING  = 3'd5
  } rc_e;

  // Additional cause codes
  typedef enum logic [2:0] {
    AC_NONE      = 3'd0,
    AC_HIERARCHY = 3'd1,
    AC_INTERLOCK = 3'd2,
    AC_REACHED   = 3'd3,
    AC_INVALID   = 3'd4
  } cause_e;

  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] PollLimitReset = 16'd1000;

  // One input word
  typedef struct packed {
    logic [2:0] req_type;
    pos_e       new_position;
    logic       flag_level;
    logic       want_closed;
  } req_t;

  // One result word
  typedef struct packed {
    rc_e        result_code;
    cause_e     add_cause;
    logic       open_drive;
    logic       close_drive;
    logic       pos_changed;
    pos_e       cur_position;
  } res_t;

endpackage

// File: design/scic_in_stage.sv
// Input register stage: captures one request word per cycle unless stalled.
module scic_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  scic_pkg::req_t in_req_i,
  output logic          req_valid_o,
  input  logic          req_stall_i,
  output scic_pkg::req_t req_o
);
  import scic_pkg::*;

  logic valid_q, valid_d;
  req_t req_q;
  logic accept;

  // Stall only when holding a word that cannot advance
  assign in_stall_o = valid_q & req_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign valid_d    = in_stall_o ? 1'b1 : in_valid_i;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

// File: design/scic_eval.sv
// Interlock state and single-pass evaluation of one request word.
module scic_eval (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         limit_we_i,
  input  logic [scic_pkg::CountW-1:0]  limit_i,
  input  logic                         adv_i,
  input  scic_pkg::req_t               req_i,
  output scic_pkg::res_t               res_o
);
  import scic_pkg::*;

  pos_e              pos_q, pos_d;
  logic              open_en_q, open_en_d;
  logic              close_en_q, close_en_d;
  logic              local_q, local_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              open_q, open_d;
  logic              close_q, close_d;
  logic [CountW-1:0] limit_q;

  logic [CountW-1:0] cnt_inc;
  logic              reached;
  rc_e               rc;
  cause_e            cause;
  logic              changed;

  assign cnt_inc = cnt_q + CountW'(1);
  assign reached = req_i.want_closed ? (pos_q == POS_ON) : (pos_q == POS_OFF);

  // Evaluate the request against the current state
  always_comb begin
    pos_d      = pos_q;
    open_en_d  = open_en_q;
    close_en_d = close_en_q;
    local_d    = local_q;
    cnt_d      = cnt_q;
    open_d     = open_q;
    close_d    = close_q;
    rc         = RC_NONE;
    cause      = AC_NONE;
    changed    = 1'b0;
    unique case (req_i.req_type)
      REQ_POS: begin
        changed = (req_i.new_position != pos_q);
        pos_d   = req_i.new_position;
      end
      REQ_OPEN_EN:  open_en_d  = req_i.flag_level;
      REQ_CLOSE_EN: close_en_d = req_i.flag_level;
      REQ_LOCAL:    local_d    = req_i.flag_level;
      REQ_CHECK: begin
        if (local_q) begin
          rc    = RC_DENIED;
          cause = AC_HIERARCHY;
        end else if (req_i.want_closed ? close_en_q : open_en_q) begin
          rc = RC_ACCEPTED;
        end else begin
          rc    = RC_DENIED;
          cause = AC_INTERLOCK;
        end
      end
      REQ_POLL: begin
        // Raise the command on the first poll of a move
        if (cnt_q == '0) begin
          if (req_i.want_closed) close_d = 1'b1;
          else                   open_d  = 1'b1;
        end
        if (reached) begin
          cnt_d = '0;
          if (pos_q == POS_ON) close_d = 1'b0;
          else                 open_d  = 1'b0;
          rc    = RC_OK;
          cause = AC_REACHED;
        end else if (pos_q == POS_BAD || cnt_inc >= limit_q) begin
          cnt_d   = '0;
          open_d  = 1'b0;
          close_d = 1'b0;
          rc      = RC_FAILED;
          cause   = AC_INVALID;
        end else begin
          cnt_d = cnt_inc;
          rc    = RC_WAITING;
        end
      end
      default: ;
    endcase
  end

  // Commit state when the word advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_INTERMEDIATE;
      open_en_q  <= 1'b1;
      close_en_q <= 1'b1;
      local_q    <= 1'b0;
      cnt_q      <= '0;
      open_q     <= 1'b0;
      close_q    <= 1'b0;
    end else if (adv_i) begin
      pos_q      <= pos_d;
      open_en_q  <= open_en_d;
      close_en_q <= close_en_d;
      local_q    <= local_d;
      cnt_q      <= cnt_d;
      open_q     <= open_d;
      close_q    <= close_d;
    end
  end

  // Hold the poll limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= PollLimitReset;
    end else if (limit_we_i) begin
      limit_q <= limit_i;
    end
  end

  assign res_o.result_code  = rc;
  assign res_o.add_cause    = cause;
  assign res_o.open_drive   = open_d;
  assign res_o.close_drive  = close_d;
  assign res_o.pos_changed  = changed;
  assign res_o.cur_position = pos_d;

  // A failed poll drops both commands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.result_code == RC_FAILED |=> !open_q && !close_q)
    else $error("commands still set after failed move");

  // Only polls touch the poll counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && req_i.req_type != REQ_POLL |=> $stable(cnt_q))
    else $error("poll counter moved on non-poll request");

  // Counter stays below the largest limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != {CountW{1'b1}})
    else $error("poll counter reached all ones");

  // Position change flag only on position updates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && req_i.req_type != REQ_POS |-> !res_o.pos_changed)
    else $error("position change flagged on other request");

endmodule

// File: design/scic_out_stage.sv
// Result register stage: holds one result word until taken.
module scic_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  output logic           res_stall_o,
  input  scic_pkg::res_t res_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output scic_pkg::res_t out_res_o
);
  import scic_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Stall upstream only while a held result is not taken
  assign res_stall_o = valid_q & out_stall_i;
  assign valid_d     = res_stall_o ? 1'b1 : res_valid_i;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load a new result when free
  always_ff @(posedge clk_i) begin
    if (res_valid_i && !res_stall_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

// File: design/switch_control_interlock.sv
// Top level of the switch control interlock.
//
// Usage: one request word enters on in_valid_i/in_stall_o with its fields
// (req_type_i, new_position_i, flag_level_i, want_closed_i) and is taken
// at an edge where in_valid_i is high and in_stall_o is low. Each word
// yields exactly one result word on out_valid_o/out_stall_i, taken where
// out_valid_o is high and out_stall_i is low.
// Flow: a taken word goes from the input register through the evaluation
// logic into the result register, where its result is offered.
// Throughput: one word per cycle while out_stall_i does not hold the result;
// the breaker state updates as the word moves into the result register.
// poll_limit_we_i/poll_limit_i write the poll limit; write it
// only while no word is in flight.
// Reset (rst_ni low, asynchronous): position intermediate, both enables
// set, local mode off, counter and commands cleared, poll limit 1000, both
// stages empty.
// Receiver stall: the result word holds; one more word may still enter the
// input register, after which in_stall_o rises until the result is taken.
module switch_control_interlock (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        poll_limit_we_i,
  input  logic [15:0] poll_limit_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [1:0]  new_position_i,
  input  logic        flag_level_i,
  input  logic        want_closed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  result_code_o,
  output logic [2:0]  add_cause_o,
  output logic        open_drive_o,
  output logic        close_drive_o,
  output logic        pos_changed_o,
  output logic [1:0]  cur_position_o
);
  import scic_pkg::*;

  req_t in_req, req;
  res_t res, out_res;
  logic req_valid, res_stall, adv;

  assign in_req.req_type     = req_type_i;
  assign in_req.new_position = pos_e'(new_position_i);
  assign in_req.flag_level   = flag_level_i;
  assign in_req.want_closed  = want_closed_i;

  // Capture incoming words
  scic_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .req_valid_o (req_valid),
    .req_stall_i (res_stall),
    .req_o       (req)
  );

  // Evaluate when the word moves into the result register
  assign adv = req_valid & ~res_stall;

  scic_eval u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_we_i (poll_limit_we_i),
    .limit_i    (poll_limit_i),
    .adv_i      (adv),
    .req_i      (req),
    .res_o      (res)
  );

  // Hold results for the receiver
  scic_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (req_valid),
    .res_stall_o (res_stall),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign result_code_o  = out_res.result_code;
  assign add_cause_o    = out_res.add_cause;
  assign open_drive_o   = out_res.open_drive;
  assign close_drive_o  = out_res.close_drive;
  assign pos_changed_o  = out_res.pos_changed;
  assign cur_position_o = out_res.cur_position;

endmodule
